// ===== rtl/core/dmc_pkg.sv =====
// Package for the DEFLATE match copy unit: item structs, status and function
// codes, state machine encoding and the length/distance code tables.
// No dependencies.
package dmc_pkg;

    typedef enum logic [1:0] {
        FUNC_LITERAL = 2'd0,
        FUNC_MATCH   = 2'd1,
        FUNC_RESTART = 2'd2,
        FUNC_UNUSED  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_LEN   = 3'd1,
        ST_BAD_DIST  = 3'd2,
        ST_TOO_FAR   = 3'd3,
        ST_LIMIT     = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  literal_byte;
        logic [8:0]  length_symbol;
        logic [4:0]  length_extra;
        logic [4:0]  distance_code;
        logic [12:0] distance_extra;
    } in_item_t;

    typedef struct packed {
        logic [63:0] out_bytes;
        logic [3:0]  byte_count;
        logic        last;
        logic [2:0]  status;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_READ,
        S_WRITE,
        S_EMIT,
        S_WAIT
    } fsm_state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;       // capture input item and decode
        logic restart;    // clear produced count
        logic lit_write;  // write literal into history
        logic rd_issue;   // read history at copy source
        logic cp_write;   // write copied byte, advance count
        logic emit;       // load output register
        logic emit_last;
        logic [2:0] emit_status;
        logic clear_acc;
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic [1:0] func;
        logic bad_len;
        logic bad_dist;
        logic too_far;
        logic at_limit;
        logic len_done;   // all bytes of the match copied
        logic acc_full;
        logic out_busy;
    } dp_stat_t;

    localparam int LenCodes  = 29;
    localparam int DistCodes = 30;

    function automatic logic [8:0] len_base(input logic [4:0] i);
        logic [8:0] t [0:LenCodes-1];
        t = '{9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9, 9'd10, 9'd11, 9'd13,
              9'd15, 9'd17, 9'd19, 9'd23, 9'd27, 9'd31, 9'd35, 9'd43, 9'd51,
              9'd59, 9'd67, 9'd83, 9'd99, 9'd115, 9'd131, 9'd163, 9'd195,
              9'd227, 9'd258};
        return (i < 5'(LenCodes)) ? t[i] : 9'd0;
    endfunction

    function automatic logic [2:0] len_bits(input logic [4:0] i);
        logic [2:0] t [0:LenCodes-1];
        t = '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1,
              3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3,
              3'd4, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd5, 3'd0};
        return (i < 5'(LenCodes)) ? t[i] : 3'd0;
    endfunction

    function automatic logic [14:0] dist_base(input logic [4:0] i);
        logic [14:0] t [0:DistCodes-1];
        t = '{15'd1, 15'd2, 15'd3, 15'd4, 15'd5, 15'd7, 15'd9, 15'd13, 15'd17,
              15'd25, 15'd33, 15'd49, 15'd65, 15'd97, 15'd129, 15'd193,
              15'd257, 15'd385, 15'd513, 15'd769, 15'd1025, 15'd1537,
              15'd2049, 15'd3073, 15'd4097, 15'd6145, 15'd8193, 15'd12289,
              15'd16385, 15'd24577};
        return (i < 5'(DistCodes)) ? t[i] : 15'd0;
    endfunction

    function automatic logic [3:0] dist_bits(input logic [4:0] i);
        return (i < 5'(DistCodes)) ? 4'(i[4:1] - ((i >= 5'd4) ? 4'd1 : 4'(i[4:1])))
                                   : 4'd0;
    endfunction

endpackage

// ===== rtl/core/dmc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module dmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== rtl/core/dmc_ctrl.sv =====
// Controller state machine of the match copy unit.
// Depends on dmc_pkg.
module dmc_ctrl
    import dmc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_stat_t   stat,
    output dp_cmd_t    cmd
);
    fsm_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.clear_acc = 1'b1;
                unique case (func_t'(stat.func))
                    FUNC_RESTART: begin
                        cmd.restart = 1'b1;
                        state_next = S_IDLE;
                    end
                    FUNC_UNUSED: state_next = S_IDLE;
                    FUNC_LITERAL: begin
                        if (!stat.out_busy) begin
                            cmd.emit = 1'b1;
                            cmd.emit_last = 1'b1;
                            if (stat.at_limit) begin
                                cmd.emit_status = ST_LIMIT;
                            end else begin
                                cmd.lit_write = 1'b1;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    FUNC_MATCH: begin
                        priority if (stat.bad_len || stat.bad_dist || stat.too_far) begin
                            if (!stat.out_busy) begin
                                cmd.emit = 1'b1;
                                cmd.emit_last = 1'b1;
                                cmd.emit_status = stat.bad_len  ? ST_BAD_LEN :
                                                  stat.bad_dist ? ST_BAD_DIST : ST_TOO_FAR;
                                state_next = S_IDLE;
                            end
                        end else begin
                            state_next = S_READ;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_READ: begin
                // A full group with bytes still to copy goes out before the
                // limit is looked at, so a copy cut at a group boundary ends in an empty result.
                priority if (stat.len_done) begin
                    state_next = S_EMIT;
                end else if (stat.acc_full) begin
                    state_next = S_WAIT;
                end else if (stat.at_limit) begin
                    state_next = S_EMIT;
                end else begin
                    cmd.rd_issue = 1'b1;
                    state_next = S_WRITE;
                end
            end
            S_WRITE: begin
                cmd.cp_write = 1'b1;
                state_next = S_READ;
            end
            S_WAIT: begin
                // Full group with more bytes to come: push a non-final result.
                if (!stat.out_busy) begin
                    cmd.emit = 1'b1;
                    cmd.clear_acc = 1'b1;
                    state_next = S_READ;
                end
            end
            S_EMIT: begin
                if (!stat.out_busy) begin
                    cmd.emit = 1'b1;
                    cmd.emit_last = 1'b1;
                    cmd.emit_status = stat.len_done ? ST_OK : ST_LIMIT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

// ===== rtl/core/dmc_datapath.sv =====
// Datapath of the match copy unit: decode, history RAM, byte packing and
// the output register. Depends on dmc_pkg, dmc_ram.
module dmc_datapath
    import dmc_pkg::*;
#(
    parameter int HISTORY_DEPTH    = 32768,
    parameter int BYTES_PER_RESULT = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  in_item_t   s_item,
    input  logic       cfg_valid,
    input  logic [23:0] cfg_data,
    input  dp_cmd_t    cmd,
    output dp_stat_t   stat,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_item
);
    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(BYTES_PER_RESULT + 1);

    in_item_t    item_reg;
    logic [23:0] limit_reg;
    logic [23:0] count_reg;
    logic [8:0]  remain_reg;
    logic [15:0] dist_reg;
    logic [63:0] acc_reg;
    logic [CW-1:0] cnt_reg;
    logic        out_valid_reg;
    out_item_t   out_reg;

    logic [4:0]  li;
    logic [8:0]  length;
    logic [15:0] match_dist;
    logic [7:0]  rdata;
    logic        we;
    logic [7:0]  wdata;

    assign li = 5'(item_reg.length_symbol - 9'd257);
    assign length = len_base(li)
        + 9'(item_reg.length_extra & 5'((6'd1 << len_bits(li)) - 6'd1));
    assign match_dist = 16'(dist_base(item_reg.distance_code))
        + 16'(item_reg.distance_extra
              & 13'((14'd1 << dist_bits(item_reg.distance_code)) - 14'd1));

    assign stat.func     = item_reg.func;
    assign stat.bad_len  = (item_reg.length_symbol < 9'd257)
                        || (item_reg.length_symbol > 9'd285);
    assign stat.bad_dist = item_reg.distance_code >= 5'd30;
    assign stat.too_far  = (24'(match_dist) > count_reg)
                        || (32'(match_dist) > 32'(HISTORY_DEPTH));
    assign stat.at_limit = count_reg >= limit_reg;
    assign stat.len_done = remain_reg == 9'd0;
    assign stat.acc_full = cnt_reg == CW'(BYTES_PER_RESULT);
    assign stat.out_busy = out_valid_reg && !m_ready;

    assign we    = cmd.lit_write || cmd.cp_write;
    assign wdata = cmd.lit_write ? item_reg.literal_byte : rdata;

    dmc_ram #(.WIDTH(8), .DEPTH(HISTORY_DEPTH)) u_hist (
        .aclk  (aclk),
        .we    (we),
        .waddr (count_reg[AW-1:0]),
        .wdata (wdata),
        .re    (cmd.rd_issue),
        .raddr (AW'(count_reg - 24'(dist_reg))),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg     <= 24'hFFFFFF;
            count_reg     <= '0;
            remain_reg    <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                limit_reg <= cfg_data;
            end
            if (cmd.restart) begin
                count_reg <= '0;
            end
            if (cmd.clear_acc) begin
                cnt_reg <= '0;
                acc_reg <= '0;
            end
            // The wait state clears only the byte group, not the match setup.
            if (cmd.clear_acc && !cmd.emit) begin
                remain_reg <= length;
                dist_reg   <= match_dist;
            end
            if (cmd.lit_write) begin
                count_reg <= count_reg + 24'd1;
            end
            if (cmd.cp_write) begin
                count_reg  <= count_reg + 24'd1;
                remain_reg <= remain_reg - 9'd1;
                acc_reg    <= acc_reg | (64'(rdata) << {cnt_reg, 3'b000});
                cnt_reg    <= cnt_reg + CW'(1);
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_valid && m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_item;
        end
        if (cmd.emit) begin
            if (item_reg.func == FUNC_LITERAL) begin
                out_reg.out_bytes  <= cmd.emit_status == ST_OK ?
                                      64'(item_reg.literal_byte) : 64'd0;
                out_reg.byte_count <= cmd.emit_status == ST_OK ? 4'd1 : 4'd0;
            end else if (cmd.emit_status == ST_BAD_LEN || cmd.emit_status == ST_BAD_DIST
                         || cmd.emit_status == ST_TOO_FAR) begin
                out_reg.out_bytes  <= '0;
                out_reg.byte_count <= '0;
            end else begin
                out_reg.out_bytes  <= acc_reg;
                out_reg.byte_count <= 4'(cnt_reg);
            end
            out_reg.last   <= cmd.emit_last;
            out_reg.status <= cmd.emit_status;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;
endmodule

// ===== rtl/core/deflate_match_copy_unit.sv =====
// Top level of the DEFLATE match copy unit: joins controller and datapath.
// Depends on dmc_pkg, dmc_ctrl, dmc_datapath, dmc_ram.
//
// This block resolves DEFLATE length/distance pairs against a history
// window and emits the copied bytes packed BYTES_PER_RESULT to a result
// item, the final item of each literal or match input marked by last.
// Literal items append one byte, restart items reset the produced count,
// and bad codes, a too distant match or the output limit are reported in
// status. Items are taken one at a time; each copied byte is read from the
// history RAM and then written, which also makes overlapping copies exact.
// A result that waits to be taken holds up the next result. The output
// register lets the block move on while the last result waits to be taken.
// The user must write output_limit through the cfg channel only while the
// block is idle; the block itself does not enforce this.
module deflate_match_copy_unit
    import dmc_pkg::*;
#(
    parameter int HISTORY_DEPTH    = 32768,
    parameter int BYTES_PER_RESULT = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_item,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] cfg_data
);
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Configuration is always taken; the user must write it only while idle, the block does not enforce this.
    assign cfg_ready = 1'b1;

    dmc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    dmc_datapath #(
        .HISTORY_DEPTH    (HISTORY_DEPTH),
        .BYTES_PER_RESULT (BYTES_PER_RESULT)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_item    (s_item),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );
endmodule
